// File: rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, sizes and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 12;
  localparam int ADDR_W       = 24;
  localparam int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_code_t;

  typedef enum logic {
    STAT_OK   = 1'b0,
    STAT_FAIL = 1'b1
  } stat_code_t;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic              status;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              free;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic quick;
    logic hit;
    logic exhausted;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer of the allocator: accepts a request, runs the table walk and
// commits the result once the output register can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl
  import ffa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t st,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        // Trivial requests skip the walk entirely.
        if (st.quick || st.hit || st.exhausted) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ffa_datapath.sv
// ----------------------------------------------------------------------------
// ffa_datapath
// Block table memory, break and count registers, table walk and result
// register of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_datapath
  import ffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire req_t              in_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_wr_data,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             st,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rsp_t                   out_data
);

  entry_t            mem [MAX_BLOCKS];
  entry_t            rd_entry;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  logic [ADDR_W-1:0] heap_limit;
  logic [ADDR_W-1:0] heap_break;
  logic [ADDR_W-1:0] heap_break_next;
  logic [CNT_W-1:0]  block_count;
  logic [CNT_W-1:0]  block_count_next;

  req_t              req;
  logic [CNT_W-1:0]  issue_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              found;
  logic [IDX_W-1:0]  hit_idx;
  entry_t            hit_entry;
  logic              match;
  logic              more;
  rsp_t              rsp_next;
  logic [ADDR_W+1:0] new_break;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= mem[issue_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= {ADDR_W{1'b1}};
    end else if (cfg_wr_en) begin
      heap_limit <= cfg_wr_data;
    end
  end

  assign more = issue_idx < block_count;

  // Walk condition on the entry read in the previous cycle.
  always_comb begin
    if (req.req_type == REQ_ALLOC) begin
      match = pend && rd_entry.free && (rd_entry.size >= req.req_size);
    end else begin
      match = pend && (({1'b0, rd_entry.start} + (ADDR_W+1)'(HEADER_BYTES))
                       == {1'b0, req.block_addr});
    end
  end

  always_comb begin
    st.quick = (req.req_type == REQ_ALLOC) ? (req.req_size == '0)
             : ((req.block_addr == '0) || (block_count == '0));
    st.hit       = match;
    st.exhausted = !pend && !more;
    st.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.start) begin
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      pend <= more;
      if (match) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req       <= in_data;
      issue_idx <= '0;
    end else if (cmd.scan) begin
      if (more) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
      pend_idx <= issue_idx[IDX_W-1:0];
      if (match) begin
        hit_idx   <= pend_idx;
        hit_entry <= rd_entry;
      end
    end
  end

  assign new_break = {2'b00, heap_break} + (ADDR_W+2)'(HEADER_BYTES) + {2'b00, req.req_size};

  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = hit_idx;
    mem_wdata        = hit_entry;
    heap_break_next  = heap_break;
    block_count_next = block_count;
    rsp_next.result_addr = '0;
    rsp_next.status      = STAT_OK;
    if (req.req_type == REQ_ALLOC) begin
      if (st.quick) begin
        rsp_next.status = STAT_OK;
      end else if (found) begin
        mem_we               = cmd.commit;
        mem_wdata.free       = 1'b0;
        rsp_next.result_addr = hit_entry.start + ADDR_W'(HEADER_BYTES);
      end else if ((block_count >= CNT_W'(MAX_BLOCKS)) ||
                   (new_break > {2'b00, heap_limit})) begin
        rsp_next.status = STAT_FAIL;
      end else begin
        mem_we               = cmd.commit;
        mem_waddr            = block_count[IDX_W-1:0];
        mem_wdata.start      = heap_break;
        mem_wdata.size       = req.req_size;
        mem_wdata.free       = 1'b0;
        block_count_next     = block_count + CNT_W'(1);
        heap_break_next      = new_break[ADDR_W-1:0];
        rsp_next.result_addr = heap_break + ADDR_W'(HEADER_BYTES);
      end
    end else begin
      if (st.quick || !found || hit_entry.free) begin
        rsp_next.status = STAT_FAIL;
      end else if (CNT_W'(hit_idx) == (block_count - CNT_W'(1))) begin
        // Releasing the top block hands its space back to the break.
        block_count_next = block_count - CNT_W'(1);
        heap_break_next  = hit_entry.start;
      end else begin
        mem_we         = cmd.commit;
        mem_wdata.free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_break  <= '0;
      block_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        heap_break  <= heap_break_next;
        block_count <= block_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an address-ordered table of heap blocks.
// ----------------------------------------------------------------------------
// Each transaction takes one allocate or release request and returns one
// result. A request walks the block table one entry per cycle through the
// single read port of the table memory. A walk stops on the first entry
// that matches or once it has run past all entries of the table.
// Zero-size allocates, null releases and requests on an empty table skip
// the walk. A finished request waits for the output register to free up,
// and the controller returns to idle as the result is loaded, ready to take
// the next request. One request is in work at a time; a new request is
// accepted while the previous result still waits in the output register.
// The table needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator
  import ffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire req_t              in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rsp_t                   out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_wr_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ffa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_checker
  import ffa_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rsp_t out_data
);

  // A waiting result must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one request is in work, so nothing is taken right after a request.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted during a table walk");

  // Failures never carry an address.
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STAT_FAIL) |-> out_data.result_addr == '0)
    else $error("failed transaction carries an address");

  // A granted payload always lies past its block header.
  a_past_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STAT_OK) && (out_data.result_addr != '0)
    |-> out_data.result_addr >= ADDR_W'(HEADER_BYTES))
    else $error("payload address inside a header");

endmodule

bind first_fit_heap_allocator ffa_checker u_checker (.*);

`default_nettype wire
